/* hdl/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants, state codes and default record types for the LRU
// page-frame store.
// ----------------------------------------------------------------------------
package lru_pkg;

	// defaults for the top-level parameters
	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 16;

	// fixed field widths of the streams and the register
	localparam int PAGE_NUM_W    = 16;
	localparam int FRAME_IDX_W   = 4;
	localparam int TOTAL_W       = 32;
	localparam int CFG_W         = 5;
	localparam int OUT_PAD_W     = 3;
	localparam int OUT_TDATA_W   = FRAME_IDX_W + 1 + PAGE_NUM_W + 2 * TOTAL_W + OUT_PAD_W;

	localparam logic [CFG_W-1:0]   ACTIVE_RESET = CFG_W'(16);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

	// widths derived from the default frame count
	localparam int DEF_IDX_W = (MAX_FRAMES_DEF > 1) ? $clog2(MAX_FRAMES_DEF) : 1;
	localparam int DEF_CNT_W = $clog2(MAX_FRAMES_DEF + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// search record handed from cell to cell (default widths)
	typedef struct packed {
		logic [PAGE_BITS_DEF-1:0] page;
		logic [DEF_CNT_W-1:0]     count;
		logic                     found;
		logic [DEF_IDX_W-1:0]     hit_k;
		logic [DEF_IDX_W-1:0]     hit_rank;
		logic                     empty;
		logic [DEF_IDX_W-1:0]     empty_k;
		logic                     min_ok;
		logic [DEF_IDX_W-1:0]     min_k;
		logic [DEF_IDX_W-1:0]     min_rank;
		logic [PAGE_BITS_DEF-1:0] min_page;
	} scan_t;

	// update broadcast to all cells (default widths)
	typedef struct packed {
		logic                     en;
		logic                     clear;
		logic                     fill;
		logic [DEF_IDX_W-1:0]     k;
		logic [DEF_IDX_W-1:0]     old_rank;
		logic [DEF_IDX_W-1:0]     new_rank;
		logic [PAGE_BITS_DEF-1:0] page;
	} upd_t;

endpackage

/* hdl/lru_cell.sv */
// ----------------------------------------------------------------------------
// lru_cell
// One page frame: holds page, valid bit and recency rank, folds its frame
// into the passing search record and applies the broadcast update.
// ----------------------------------------------------------------------------
module lru_cell #(
	parameter int  INDEX     = 0,
	parameter int  MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
	parameter int  PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter type SCAN_T     = lru_pkg::scan_t,
	parameter type UPD_T      = lru_pkg::upd_t
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_win,
	input  logic  tok_in,
	input  SCAN_T acc_in,
	output logic  tok_out,
	output SCAN_T acc_out,
	input  UPD_T  upd
);
	import lru_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IDX_W-1:0]     rank_q;
	logic                 tok_q;
	SCAN_T                acc_q;
	SCAN_T                acc_nx;
	logic                 act;
	logic                 self;

	assign act  = in_win & valid_q;
	assign self = (upd.k == IDX_W'(INDEX));

	always_comb begin
		acc_nx = acc_in;
		if (act) begin
			acc_nx.count = CNT_W'(acc_in.count + 1'b1);
		end
		if (act && !acc_in.found && page_q == acc_in.page) begin
			acc_nx.found    = 1'b1;
			acc_nx.hit_k    = IDX_W'(INDEX);
			acc_nx.hit_rank = rank_q;
		end
		if (in_win && !valid_q && !acc_in.empty) begin
			acc_nx.empty   = 1'b1;
			acc_nx.empty_k = IDX_W'(INDEX);
		end
		// strict less-than keeps the lowest index on a tie
		if (in_win && (!acc_in.min_ok || rank_q < acc_in.min_rank)) begin
			acc_nx.min_ok   = 1'b1;
			acc_nx.min_k    = IDX_W'(INDEX);
			acc_nx.min_rank = rank_q;
			acc_nx.min_page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in) begin
			acc_q <= acc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.clear) begin
				valid_q <= 1'b0;
				rank_q  <= '0;
			end else if (self) begin
				valid_q <= 1'b1;
				rank_q  <= upd.new_rank;
			end else if (!upd.fill && act && rank_q > upd.old_rank) begin
				rank_q <= IDX_W'(rank_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && !upd.clear && self) begin
			page_q <= upd.page;
		end
	end

	assign tok_out = tok_q;
	assign acc_out = acc_q;

endmodule

/* hdl/lru_ctrl.sv */
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer: injects an item into the cell chain, decides hit, fill or
// eviction from the finished search, broadcasts the update, keeps totals
// and drives the result register.
// ----------------------------------------------------------------------------
module lru_ctrl #(
	parameter int  MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
	parameter int  PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter type SCAN_T     = lru_pkg::scan_t,
	parameter type UPD_T      = lru_pkg::upd_t
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lru_pkg::PAGE_NUM_W-1:0]      s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lru_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tuser,
	output logic                                inj_tok,
	output SCAN_T                               inj_acc,
	input  logic                                fin_tok,
	input  SCAN_T                               fin_acc,
	output UPD_T                                upd
);
	import lru_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	state_t state_q, state_d;
	logic   commit;
	logic   out_free;
	logic   last_q;

	logic                 hit;
	logic                 fill;
	logic                 evict;
	logic [IDX_W-1:0]     k;
	logic [IDX_W-1:0]     old_rank;
	logic [IDX_W-1:0]     new_rank;
	logic [PAGE_NUM_W-1:0] ev_page;

	logic [TOTAL_W-1:0] hit_q, fault_q;
	logic [TOTAL_W-1:0] hit_nx, fault_nx;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;

	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) begin
				state_d = ST_SCAN;
			end
			ST_SCAN: if (fin_tok) begin
				state_d = ST_DONE;
			end
			ST_DONE: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: ;
			ST_DONE: commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign inj_tok = s_tvalid & s_tready;

	always_comb begin
		inj_acc      = '0;
		inj_acc.page = PAGE_BITS'(s_tdata);
	end

	always_ff @(posedge clk) begin
		if (inj_tok) begin
			last_q <= s_tlast;
		end
	end

	// decision from the finished search
	always_comb begin
		hit      = fin_acc.found;
		fill     = !fin_acc.found && fin_acc.empty;
		evict    = !fin_acc.found && !fin_acc.empty;
		k        = hit ? fin_acc.hit_k : (fill ? fin_acc.empty_k : fin_acc.min_k);
		old_rank = hit ? fin_acc.hit_rank : fin_acc.min_rank;
		new_rank = fill ? IDX_W'(fin_acc.count) : IDX_W'(fin_acc.count - 1'b1);
		ev_page  = evict ? PAGE_NUM_W'(fin_acc.min_page) : '0;
	end

	always_comb begin
		upd          = '0;
		upd.en       = commit;
		upd.clear    = last_q;
		upd.fill     = fill;
		upd.k        = k;
		upd.old_rank = old_rank;
		upd.new_rank = new_rank;
		upd.page     = fin_acc.page;
	end

	// saturating totals
	always_comb begin
		hit_nx   = hit_q;
		fault_nx = fault_q;
		if (hit) begin
			if (hit_q != TOTAL_MAX) hit_nx = TOTAL_W'(hit_q + 1'b1);
		end else begin
			if (fault_q != TOTAL_MAX) fault_nx = TOTAL_W'(fault_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= '0;
			fault_q <= '0;
		end else if (commit) begin
			hit_q   <= last_q ? '0 : hit_nx;
			fault_q <= last_q ? '0 : fault_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tuser_q <= hit;
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, fault_nx, hit_nx, ev_page, evict,
				FRAME_IDX_W'(k)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* hdl/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative page-frame store with least-recently-used replacement,
// built as a chain of frame cells that a search record walks through.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  -------------------------------------------
//  cfg      in   cfg_we              cfg_wdata: active_frames
//  s        in   s_tvalid/s_tready   s_tdata: page_number; s_tlast: last_access
//  m        out  m_tvalid/m_tready   m_tuser: hit; m_tdata: see port comment
//
//  The search record of an item steps through one frame cell per cycle,
//  then the sequencer decides and updates all frames at once; a new item
//  is accepted only after that update. arst_n clears valid bits, ranks,
//  totals and loads active_frames with 16. A stalled result waits in the
//  output register; the next item is accepted while it waits, and only
//  its own commit holds until the register frees.
//
module lru_page_replacement #(
	parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lru_pkg::CFG_W-1:0]         cfg_wdata,    // active_frames
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lru_pkg::PAGE_NUM_W-1:0]    s_tdata,      // [15:0] page_number
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [3:0] frame_index, [4] evicted_valid, [20:5] evicted_page,
	// [52:21] hit_total, [84:53] fault_total, [87:85] zero
	output logic [lru_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser       // [0] hit
);
	import lru_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	// search record: accumulates matches, fill slot and LRU victim
	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic [CNT_W-1:0]     count;
		logic                 found;
		logic [IDX_W-1:0]     hit_k;
		logic [IDX_W-1:0]     hit_rank;
		logic                 empty;
		logic [IDX_W-1:0]     empty_k;
		logic                 min_ok;
		logic [IDX_W-1:0]     min_k;
		logic [IDX_W-1:0]     min_rank;
		logic [PAGE_BITS-1:0] min_page;
	} chain_scan_t;

	// update broadcast from the sequencer to every cell
	typedef struct packed {
		logic                 en;
		logic                 clear;
		logic                 fill;
		logic [IDX_W-1:0]     k;
		logic [IDX_W-1:0]     old_rank;
		logic [IDX_W-1:0]     new_rank;
		logic [PAGE_BITS-1:0] page;
	} chain_upd_t;

	logic [CFG_W-1:0]     active_q;
	logic [MAX_FRAMES-1:0] win;

	logic                 tok   [MAX_FRAMES+1];
	chain_scan_t          acc   [MAX_FRAMES+1];
	chain_upd_t           upd;

	// hold active_frames; the user must write it only between items, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	lru_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.SCAN_T     (chain_scan_t),
		.UPD_T      (chain_upd_t)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.inj_tok  (tok[0]),
		.inj_acc  (acc[0]),
		.fin_tok  (tok[MAX_FRAMES]),
		.fin_acc  (acc[MAX_FRAMES]),
		.upd      (upd)
	);

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		// window: frame 0 is always in; above MAX_FRAMES there are no cells
		assign win[i] = (i == 0) || (int'(active_q) > i);

		lru_cell #(
			.INDEX      (i),
			.MAX_FRAMES (MAX_FRAMES),
			.PAGE_BITS  (PAGE_BITS),
			.SCAN_T     (chain_scan_t),
			.UPD_T      (chain_upd_t)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_win  (win[i]),
			.tok_in  (tok[i]),
			.acc_in  (acc[i]),
			.tok_out (tok[i+1]),
			.acc_out (acc[i+1]),
			.upd     (upd)
		);
	end

endmodule

/* hdl/lru_chk.sv */
// ----------------------------------------------------------------------------
// lru_chk
// Port-level checks for the LRU page-frame store, bound to the top level.
// ----------------------------------------------------------------------------
module lru_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lru_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input logic                              m_tuser
);
	import lru_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[4])
		else $error("eviction reported on a hit");

	// no eviction means a zero evicted page
	a_ev_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[20:5] == '0)
		else $error("evicted page set without eviction");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in the chain");

endmodule

bind lru_page_replacement lru_chk u_lru_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
